[hw/rtl/cbte_pkg.sv]
// Package for the code buffer transform engine: buffer geometry,
// opcode encoding and byte constants. No dependencies.
`default_nettype none

package cbte_pkg;

    // Buffer geometry
    localparam int CODE_BYTES  = 128;
    localparam int CHUNK_BYTES = 8;
    localparam int NUM_CHUNKS  = CODE_BYTES / CHUNK_BYTES;
    localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
    localparam int CHUNK_W     = 8 * CHUNK_BYTES;
    localparam int NUM_PAIRS   = CHUNK_BYTES / 2;

    // Field widths of one transaction
    localparam int OP_W     = 4;
    localparam int CHUNK_FW = 4;
    localparam int TAB_W    = 64;
    localparam int SEED_W   = 8;
    localparam int IN_W     = OP_W + CHUNK_FW + TAB_W + SEED_W;
    localparam int OUT_W    = 64;

    // Highest chunk, where the rotates take their seed carry
    localparam logic [CHUNK_FW-1:0] TOP_CHUNK = CHUNK_FW'(NUM_CHUNKS - 1);

    // Byte constants
    localparam logic [7:0] BYTE_LSB  = 8'h01;
    localparam logic [7:0] BYTE_MSB  = 8'h80;
    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 4'd0,
        OP_READ   = 4'd1,
        OP_SHL_OR = 4'd2,
        OP_ADD    = 4'd3,
        OP_ROTL   = 4'd4,
        OP_XOR    = 4'd5,
        OP_ROTR   = 4'd6,
        OP_SHR_OR = 4'd7,
        OP_INVERT = 4'd8
    } t_opcode;

endpackage

`default_nettype wire

[hw/rtl/code_buffer_transform_engine.sv]
// Path: the input register stage, then the result register.
// Throughput: one transaction per cycle while the result side does not stall;
// each cycle one chunk is read, transformed (bytewise or by pair rotates) and
// written back: one read-modify-write of the chunk register array sets that rate.
// Reset (synchronous, active low) clears the handshake state and the carry
// bit; the code buffer itself holds no value until a chunk is written.
// Code buffer transform engine top level; depends on cbte_pkg.
`default_nettype none

module code_buffer_transform_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [3:0] opcode, [7:4] chunk, [71:8] table_bytes, [79:72] carry_seed
    input  logic [79:0] i_s_tdata,
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [63:0] chunk_out
    output logic [63:0] o_m_tdata
);
    import cbte_pkg::*;

    // Input register stage
    logic                r_s1_vld;
    t_opcode             r_op;
    logic [CHUNK_FW-1:0] r_chunk;
    logic [TAB_W-1:0]    r_tab;
    logic [SEED_W-1:0]   r_seed;

    // Result register
    logic                r_out_vld;
    logic [OUT_W-1:0]    r_out_data;

    // Carry passed between chunks by the pairwise rotates
    logic                r_carry;
    logic                n_carry;

    // Chunk-wide buffer, one row per chunk
    logic [CHUNK_W-1:0]  r_store [NUM_CHUNKS];

    logic                s_acc;
    logic                advance;
    logic                is_top;
    logic                is_rot;
    logic [CHUNK_W-1:0]  cur;
    logic [CHUNK_W-1:0]  byte_data;
    logic [CHUNK_W-1:0]  rot_data;
    logic [CHUNK_W-1:0]  n_data;
    logic [7:0]          c_byte [NUM_PAIRS+1];   // carry entering each pair

    // The input stage moves on whenever the result register is free or drains.
    assign advance    = r_s1_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_s1_vld || advance;
    assign s_acc      = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    assign cur    = r_store[r_chunk[CHUNK_IDX_W-1:0]];
    assign is_top = (r_chunk == TOP_CHUNK);
    assign is_rot = (r_op == OP_ROTL) || (r_op == OP_ROTR);

    // Bytewise transforms, each byte independent
    always_comb begin
        for (int k = 0; k < CHUNK_BYTES; k++) begin
            unique case (r_op)
                OP_LOAD:   byte_data[8*k +: 8] = r_tab[8*k +: 8];
                OP_SHL_OR: byte_data[8*k +: 8] = {cur[8*k +: 7], 1'b0} | r_tab[8*k +: 8];
                OP_ADD:    byte_data[8*k +: 8] = cur[8*k +: 8] + r_tab[8*k +: 8];
                OP_XOR:    byte_data[8*k +: 8] = cur[8*k +: 8] ^ r_tab[8*k +: 8];
                OP_SHR_OR: byte_data[8*k +: 8] = {1'b0, cur[8*k+1 +: 7]} | r_tab[8*k +: 8];
                OP_INVERT: byte_data[8*k +: 8] = cur[8*k +: 8] ^ BYTE_ONES;
                default:   byte_data[8*k +: 8] = cur[8*k +: 8];
            endcase
        end
    end

    // Pairwise rotates. The carry into a pair is the old low byte of the pair
    // above it, so all pairs resolve in parallel. Every byte of the chunk is in a pair.
    always_comb begin
        rot_data = cur;
        if (r_op == OP_ROTL) begin
            c_byte[0] = is_top ? (r_seed & BYTE_LSB) : {7'b0, r_carry};
        end else begin
            c_byte[0] = is_top ? r_seed : (r_carry ? BYTE_MSB : BYTE_ZERO);
        end
        for (int p = 0; p < NUM_PAIRS; p++) begin
            if (r_op == OP_ROTL) begin
                rot_data[8*(CHUNK_BYTES-1-2*p) +: 8] =
                    {cur[8*(CHUNK_BYTES-1-2*p) +: 7], 1'b0} | c_byte[p];
                rot_data[8*(CHUNK_BYTES-2-2*p) +: 8] =
                    {cur[8*(CHUNK_BYTES-1-2*p) + 7], cur[8*(CHUNK_BYTES-2-2*p) + 1 +: 7]};
                c_byte[p+1] = cur[8*(CHUNK_BYTES-2-2*p) +: 8] & BYTE_LSB;
            end else begin
                rot_data[8*(CHUNK_BYTES-1-2*p) +: 8] =
                    {1'b0, cur[8*(CHUNK_BYTES-1-2*p) + 1 +: 7]} | c_byte[p];
                rot_data[8*(CHUNK_BYTES-2-2*p) +: 8] =
                    {cur[8*(CHUNK_BYTES-2-2*p) +: 7], cur[8*(CHUNK_BYTES-1-2*p)]};
                c_byte[p+1] = cur[8*(CHUNK_BYTES-2-2*p) +: 8] & BYTE_MSB;
            end
        end
        n_carry = (c_byte[NUM_PAIRS] != BYTE_ZERO);
    end

    assign n_data = is_rot ? rot_data : byte_data;

    // Handshake and carry state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_carry   <= 1'b0;
        end else begin
            if (s_acc) begin
                r_s1_vld <= 1'b1;
            end else if (advance) begin
                r_s1_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (advance && is_rot) begin
                r_carry <= n_carry;
            end
        end
    end

    // Payload registers and buffer write-back, no reset
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op    <= t_opcode'(i_s_tdata[OP_W-1:0]);
            r_chunk <= i_s_tdata[OP_W +: CHUNK_FW];
            r_tab   <= i_s_tdata[OP_W+CHUNK_FW +: TAB_W];
            r_seed  <= i_s_tdata[OP_W+CHUNK_FW+TAB_W +: SEED_W];
        end
        if (advance) begin
            r_store[r_chunk[CHUNK_IDX_W-1:0]] <= n_data;
            r_out_data                        <= OUT_W'(n_data);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/cbte_checker.sv]
// Port-level checker for the code buffer transform engine, bound to the
// top level. No package dependencies.
`default_nettype none

module cbte_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [79:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata
);

    // Result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Input only stalls when a finished result is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled with result side free");

    // A result appearing from empty comes from a transaction taken through the input stage
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready, 2))
        else $error("result without matching input transaction");

    // Nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind code_buffer_transform_engine cbte_checker u_cbte_checker (.*);

`default_nettype wire

[tb/code_buffer_transform_engine_tb.sv]
// Testbench for code_buffer_transform_engine: directed rows, then rotate sweeps
// and random transactions, checked against an in-bench model of the buffer.
// Depends on cbte_pkg and the engine RTL only.
`timescale 1ns / 1ps

module code_buffer_transform_engine_tb;
    import cbte_pkg::*;

    // Opcodes with no operation behind them; the engine treats them as a read
    localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd9;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

    localparam int RANDOM_ITEMS = 750;
    localparam int STEADY_FROM  = 300;   // window with no idling on either side
    localparam int STEADY_TO    = 420;
    localparam int MAX_PRINTS   = 100;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [CHUNK_FW-1:0] idx;
        logic [TAB_W-1:0]    tab;
        logic [SEED_W-1:0]   seed;
        bit                  has_value;   // expected chunk typed in the row
        logic [OUT_W-1:0]    value;
    } t_stim_row;

    logic              i_clk;
    logic              rst_n       = 1'b0;
    logic              s_tvalid    = 1'b0;
    logic [IN_W-1:0]   s_tdata     = '0;
    logic              m_tready    = 1'b0;
    logic              s_fixed_en  = 1'b0;
    logic [OUT_W-1:0]  s_fixed_val = '0;
    logic              steady      = 1'b0;
    wire               o_s_tready;
    wire               o_m_tvalid;
    wire [OUT_W-1:0]   o_m_tdata;

    // Mirror of the engine state
    logic [7:0]        code_mirror [CODE_BYTES];
    bit                carry_mirror;
    bit                chunk_loaded [NUM_CHUNKS];

    logic [OUT_W-1:0]  chunk_after_q [$];
    t_stim_row         stim_rows [$];
    int                mismatches  = 0;
    int                items_sent  = 0;

    code_buffer_transform_engine uut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int byte_addr(logic [CHUNK_FW-1:0] idx, int k);
        return (int'(idx) * CHUNK_BYTES + k) % CODE_BYTES;
    endfunction

    // Applies one transaction to the mirror and returns the chunk afterwards
    task automatic transform_chunk(input logic [IN_W-1:0] word,
                                   output logic [OUT_W-1:0] chunk_after);
        logic [OP_W-1:0]     op;
        logic [CHUNK_FW-1:0] idx;
        logic [TAB_W-1:0]    tab;
        logic [SEED_W-1:0]   seed;
        logic [7:0]          b, t, hi, lo, c, nxt;
        int                  k;
        op   = word[3:0];
        idx  = word[7:4];
        tab  = word[71:8];
        seed = word[79:72];
        if (op == OP_ROTL || op == OP_ROTR) begin
            // Pairs walk down from the top byte; carry chains through them
            if (op == OP_ROTL)
                c = (idx == TOP_CHUNK) ? (seed & BYTE_LSB) : {7'b0, carry_mirror};
            else
                c = (idx == TOP_CHUNK) ? seed : (carry_mirror ? BYTE_MSB : BYTE_ZERO);
            for (k = CHUNK_BYTES - 1; k >= 1; k -= 2) begin
                hi = code_mirror[byte_addr(idx, k)];
                lo = code_mirror[byte_addr(idx, k - 1)];
                if (op == OP_ROTL) begin
                    nxt = lo & BYTE_LSB;
                    lo  = (lo >> 1) | (hi & BYTE_MSB);
                    hi  = (hi << 1) | c;
                end else begin
                    nxt = lo & BYTE_MSB;
                    lo  = (lo << 1) | (hi & BYTE_LSB);
                    hi  = (hi >> 1) | c;
                end
                code_mirror[byte_addr(idx, k)]     = hi;
                code_mirror[byte_addr(idx, k - 1)] = lo;
                c = nxt;
            end
            carry_mirror = (c != BYTE_ZERO);
        end else begin
            for (k = 0; k < CHUNK_BYTES; k++) begin
                b = code_mirror[byte_addr(idx, k)];
                t = tab[8*k +: 8];
                case (op)
                    OP_LOAD:   b = t;
                    OP_SHL_OR: b = (b << 1) | t;
                    OP_ADD:    b = b + t;
                    OP_XOR:    b = b ^ t;
                    OP_SHR_OR: b = (b >> 1) | t;
                    OP_INVERT: b = b ^ BYTE_ONES;
                    default:   ;
                endcase
                code_mirror[byte_addr(idx, k)] = b;
            end
        end
        chunk_after = '0;
        for (k = 0; k < CHUNK_BYTES; k++)
            chunk_after[8*k +: 8] = code_mirror[byte_addr(idx, k)];
    endtask

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        if (mismatches < MAX_PRINTS)
            $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Result check first, then prediction for the transaction taken at this edge
    always @(posedge i_clk) begin
        logic [OUT_W-1:0] predicted;
        logic [OUT_W-1:0] oldest;
        if (rst_n) begin
            if (o_m_tvalid && m_tready) begin
                if (chunk_after_q.size() == 0) begin
                    report_mismatch("unexpected result transaction", o_m_tdata, '0);
                end else begin
                    oldest = chunk_after_q.pop_front();
                    if (o_m_tdata !== oldest)
                        report_mismatch("chunk_out mismatch", o_m_tdata, oldest);
                end
            end
            if (s_tvalid && o_s_tready) begin
                transform_chunk(s_tdata, predicted);
                chunk_after_q.push_back(s_fixed_en ? s_fixed_val : predicted);
            end
        end
    end

    // Result side: back-pressure about a third of the time, except in the window
    always @(posedge i_clk) begin
        m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 32);
    end

    // Offers one transaction and holds it until the engine takes it
    task automatic send_item(input logic [OP_W-1:0] op, input logic [CHUNK_FW-1:0] idx,
                             input logic [TAB_W-1:0] tab, input logic [SEED_W-1:0] seed,
                             input bit has_value, input logic [OUT_W-1:0] value);
        while (!steady && $urandom_range(0, 99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= {seed, tab, idx, op};
        s_fixed_en  <= has_value;
        s_fixed_val <= value;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
        steady <= (items_sent >= STEADY_FROM && items_sent < STEADY_TO);
        if (op == OP_LOAD) chunk_loaded[idx] = 1'b1;
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input logic [CHUNK_FW-1:0] idx,
                           input logic [TAB_W-1:0] tab, input logic [SEED_W-1:0] seed,
                           input bit has_value, input logic [OUT_W-1:0] value);
        t_stim_row row;
        row.op = op;  row.idx = idx;  row.tab = tab;  row.seed = seed;
        row.has_value = has_value;  row.value = value;
        stim_rows.push_back(row);
    endtask

    // Mostly random bytes, sometimes all zeros or all ones
    function automatic logic [TAB_W-1:0] rand_bytes();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [SEED_W-1:0] rand_seed();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return BYTE_ZERO;
        if (pick == 1) return BYTE_ONES;
        return SEED_W'($urandom());
    endfunction

    // Any opcode other than the two rotates
    function automatic logic [OP_W-1:0] rand_plain_op();
        logic [OP_W-1:0] op;
        op = OP_W'($urandom_range(OP_LOAD, OP_SPARE_HI));
        if (op == OP_ROTL || op == OP_ROTR) op = OP_READ;
        return op;
    endfunction

    initial begin
        logic [TAB_W-1:0]    pattern;
        logic [OP_W-1:0]     rot_op;
        logic [CHUNK_FW-1:0] idx;
        int                  pick, len, i;

        pattern = {$urandom(), $urandom()};
        // Extremes loaded first, so every later row touches written chunks only
        add_row(OP_LOAD,   4'd0,      '0, BYTE_ZERO, 1'b1, '0);
        add_row(OP_LOAD,   TOP_CHUNK, '1, BYTE_ZERO, 1'b1, '1);
        add_row(OP_LOAD,   4'd14, pattern, BYTE_ONES, 1'b1, pattern);
        add_row(OP_LOAD,   4'd1, 64'h0123_4567_89AB_CDEF, BYTE_ZERO,
                1'b1, 64'h0123_4567_89AB_CDEF);
        add_row(OP_READ,   4'd0,      '1, BYTE_ONES, 1'b1, '0);
        add_row(OP_INVERT, TOP_CHUNK, '0, BYTE_ZERO, 1'b1, '0);
        add_row(OP_INVERT, TOP_CHUNK, '0, BYTE_ZERO, 1'b1, '1);
        // Rotates: seed byte taken on the top chunk, carry register below it
        add_row(OP_ROTL,   TOP_CHUNK, '0, BYTE_ONES, 1'b0, '0);
        add_row(OP_ROTL,   4'd14,     '1, BYTE_ZERO, 1'b0, '0);
        add_row(OP_ROTR,   TOP_CHUNK, '1, BYTE_MSB,  1'b0, '0);
        add_row(OP_ROTR,   4'd14,     '0, BYTE_ONES, 1'b0, '0);
        add_row(OP_SHL_OR, 4'd1,      '1, BYTE_ZERO, 1'b1, '1);
        add_row(OP_ADD,    4'd0,      '1, BYTE_ZERO, 1'b1, '1);
        add_row(OP_ADD,    4'd0, {CHUNK_BYTES{BYTE_LSB}}, BYTE_ZERO, 1'b1, '0);
        add_row(OP_XOR,    4'd14, {$urandom(), $urandom()}, BYTE_ZERO, 1'b0, '0);
        add_row(OP_SHR_OR, 4'd1,      '0, BYTE_ZERO, 1'b0, '0);
        // Spare opcodes leave the chunk alone
        add_row(OP_SPARE_HI, TOP_CHUNK, '1, BYTE_ONES, 1'b0, '0);
        add_row(OP_SPARE_LO, 4'd0,      '1, BYTE_ZERO, 1'b1, '0);

        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;

        foreach (stim_rows[r])
            send_item(stim_rows[r].op, stim_rows[r].idx, stim_rows[r].tab,
                      stim_rows[r].seed, stim_rows[r].has_value, stim_rows[r].value);

        // Fill the rest of the buffer before anything reads it
        for (i = 0; i < NUM_CHUNKS; i++)
            if (!chunk_loaded[i])
                send_item(OP_LOAD, CHUNK_FW'(i), rand_bytes(), rand_seed(), 1'b0, '0);

        while (items_sent < stim_rows.size() + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                // Full rotate sweep, top chunk down to 0, now and then a plain op between
                rot_op = $urandom_range(0, 1) ? OP_ROTL : OP_ROTR;
                for (i = NUM_CHUNKS - 1; i >= 0; i--) begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(rand_plain_op(), CHUNK_FW'($urandom()), rand_bytes(),
                                  rand_seed(), 1'b0, '0);
                    send_item(rot_op, CHUNK_FW'(i), rand_bytes(), rand_seed(), 1'b0, '0);
                end
            end else if (pick < 60) begin
                // Broken sweep: odd start, short run, mixed directions
                idx = CHUNK_FW'($urandom());
                len = $urandom_range(1, 6);
                for (i = 0; i < len; i++) begin
                    rot_op = $urandom_range(0, 1) ? OP_ROTL : OP_ROTR;
                    send_item(rot_op, idx, rand_bytes(), rand_seed(), 1'b0, '0);
                    idx = idx - 1'b1;
                end
            end else if (pick < 72) begin
                send_item(OP_LOAD, CHUNK_FW'($urandom()), rand_bytes(), rand_seed(),
                          1'b0, '0);
            end else begin
                send_item(rand_plain_op(), CHUNK_FW'($urandom()), rand_bytes(),
                          rand_seed(), 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (chunk_after_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (chunk_after_q.size() != 0)
            report_mismatch("results still outstanding", '0, OUT_W'(chunk_after_q.size()));

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/cbte_pkg.sv
hw/rtl/code_buffer_transform_engine.sv
hw/rtl/cbte_checker.sv
tb/code_buffer_transform_engine_tb.sv
